// ===== rtl/txrb_pkg.sv =====
// Shared types, constants and helpers for the transmit ring buffer with
// line-feed expansion. No dependencies; every other rtl file imports it.
`timescale 1ns / 1ps

package txrb_pkg;

    // Ring geometry: DEPTH slots, one always kept free
    localparam int DEPTH = 8;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Character codes
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    // Output word padding up to whole bytes
    localparam int RES_W  = 13;
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [0:0] {
        OP_PUSH  = 1'b0,
        OP_READY = 1'b1
    } opcode_t;

    typedef logic [PTR_W-1:0] ptr_t;

    // One input item
    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] data_byte;
    } txrb_item_t;

    // One result item, first field in the highest bits
    typedef struct packed {
        logic       queue_full;
        logic       queue_empty;
        logic       send_request;
        logic [7:0] send_byte;
        logic       send_valid;
        logic       push_accepted;
    } txrb_result_t;

    // Advance a ring position with wrap at DEPTH
    function automatic ptr_t ring_next(input ptr_t pos);
        ptr_t nxt;
        if (pos == ptr_t'(DEPTH - 1))
            nxt = '0;
        else
            nxt = pos + 1'b1;
        return nxt;
    endfunction

endpackage

// ===== rtl/tx_ring_buffer_crlf_core.sv =====
// Top level of the transmit ring buffer with LF to CR-LF expansion.
// Depends on txrb_pkg, txrb_in_stage, txrb_queue and txrb_out_stage.
//
//   channel  direction  fields
//   s_axis   in         tuser: opcode; tdata: data_byte
//   m_axis   out        tdata: push_accepted, send_valid, send_byte,
//                              send_request, queue_empty, queue_full
//
// One item per cycle sustained while m_tready stays high. An item taken
// passes the input register, then with the queue step reaches the result
// register, which raises m_tvalid. The queue state is updated in the same
// cycle the result is registered.
// Reset clears pointers, the last-sent byte and the send request; the byte
// store needs no clearing. A stalled output holds the queue stage and then
// the input register; s_tready falls as soon as the input register holds an
// item, at most one transfer after the stall begins.
`timescale 1ns / 1ps

module tx_ring_buffer_crlf_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] push_accepted, [1] send_valid,
                                   // [9:2] send_byte, [10] send_request,
                                   // [11] queue_empty, [12] queue_full
);
    import txrb_pkg::*;

    txrb_item_t   in_item;
    txrb_item_t   item;
    logic         item_valid;
    logic         out_free;
    logic         fire;
    txrb_result_t result;
    txrb_result_t out_result;

    // Unpack the incoming transfer
    assign in_item.opcode    = opcode_t'(s_tuser);
    assign in_item.data_byte = s_tdata;

    // Step the queue when an item waits and the result register can take it
    assign fire = item_valid && out_free;

    txrb_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    txrb_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (fire),
        .item   (item),
        .result (result)
    );

    txrb_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .result     (result),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .free       (out_free),
        .out_result (out_result)
    );

    // Pack the result, zero-filled to whole bytes
    assign m_tdata = {{(TDATA_W - RES_W){1'b0}}, out_result};

`ifndef SYNTH
    // A single item never both stores and sends
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(result.push_accepted && result.send_valid))
        else $error("push and send in the same item");

    // A stored byte leaves the queue non-empty with the request raised
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && result.push_accepted) |-> (result.send_request && !result.queue_empty))
        else $error("accepted push without request or with empty queue");

    // Empty and full are exclusive
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !(result.queue_empty && result.queue_full))
        else $error("queue reported empty and full");

    // A registered result follows every step
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_tvalid)
        else $error("result lost after queue step");
`endif

endmodule

// ===== rtl/txrb_in_stage.sv =====
// Input register of the transmit ring buffer: captures one transfer and
// holds it until the queue stage consumes it. Depends on txrb_pkg.
`timescale 1ns / 1ps

module txrb_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  txrb_pkg::txrb_item_t in_item,
    input  logic                take,
    output logic                item_valid,
    output txrb_pkg::txrb_item_t item
);
    import txrb_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    txrb_item_t item_reg;

    // Accept when empty or when the held item leaves this cycle
    assign in_ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Hold payload; load on each accepted transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/txrb_queue.sv =====
// Ring storage, pointers and CR insertion for the transmit ring buffer.
// Processes one item per step. Depends on txrb_pkg.
`timescale 1ns / 1ps

module txrb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  txrb_pkg::txrb_item_t  item,
    output txrb_pkg::txrb_result_t result
);
    import txrb_pkg::*;

    logic [7:0] store_reg [DEPTH];
    ptr_t       wp_reg;
    ptr_t       wp_next;
    ptr_t       rp_reg;
    ptr_t       rp_next;
    logic [7:0] last_reg;
    logic [7:0] last_next;
    logic       req_reg;
    logic       req_next;

    logic       is_empty;
    logic       is_full;
    ptr_t       wp_inc;
    logic [7:0] head_byte;
    logic       insert_cr;
    logic       do_write;
    logic       accepted;
    logic       valid;
    logic [7:0] sent;

    assign wp_inc    = ring_next(wp_reg);
    assign is_empty  = (rp_reg == wp_reg);
    assign is_full   = (wp_inc == rp_reg);
    assign head_byte = store_reg[rp_reg];
    assign insert_cr = (head_byte == CH_LF) && (last_reg != CH_CR);

    // Decode the item and work out the next queue state
    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        last_next = last_reg;
        req_next  = req_reg;
        do_write  = 1'b0;
        accepted  = 1'b0;
        valid     = 1'b0;
        sent      = 8'h00;
        unique case (item.opcode)
            OP_PUSH:
            begin
                if (!is_full)
                begin
                    do_write = 1'b1;
                    wp_next  = wp_inc;
                    req_next = 1'b1;
                    accepted = 1'b1;
                end
            end
            OP_READY:
            begin
                if (is_empty)
                begin
                    req_next = 1'b0;
                end
                else
                begin
                    valid = 1'b1;
                    if (insert_cr)
                    begin
                        sent = CH_CR;
                    end
                    else
                    begin
                        sent    = head_byte;
                        rp_next = ring_next(rp_reg);
                    end
                    last_next = sent;
                end
            end
            default:
            begin
                req_next = req_reg;
            end
        endcase
    end

    // Build the result from the state after this item
    always_comb
    begin
        result.push_accepted = accepted;
        result.send_valid    = valid;
        result.send_byte     = sent;
        result.send_request  = req_next;
        result.queue_empty   = (rp_next == wp_next);
        result.queue_full    = (ring_next(wp_next) == rp_next);
    end

    // Advance control state on each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            last_reg <= 8'h00;
            req_reg  <= 1'b0;
        end
        else if (step)
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            last_reg <= last_next;
            req_reg  <= req_next;
        end
    end

    // Store pushed bytes
    always_ff @(posedge clk)
    begin
        if (step && do_write)
            store_reg[wp_reg] <= item.data_byte;
    end

endmodule

// ===== rtl/txrb_out_stage.sv =====
// Output register of the transmit ring buffer: holds one result until the
// downstream side takes the transfer. Depends on txrb_pkg.
`timescale 1ns / 1ps

module txrb_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  txrb_pkg::txrb_result_t result,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  free,
    output txrb_pkg::txrb_result_t out_result
);
    import txrb_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    txrb_result_t result_reg;

    // Free when empty or when the held result leaves this cycle
    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            result_reg <= result;
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
